>>> src/rfb_pkg.sv
// Package for the RTU frame builder: job format between front and back,
// status codes, CRC constants and the byte-wide CRC update.
// No dependencies.
package rfb_pkg;

	// Default configuration
	localparam int MAX_WORDS_DEF   = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Field widths
	localparam int OP_W   = 2;
	localparam int BYTE_W = 8;
	localparam int WORD_W = 16;
	localparam int ST_W   = 2;
	localparam int CNT_W  = 8;   // a validated count is at most MAX_WORDS
	localparam int IDX_W  = 3;   // longest job is eight bytes

	// Operation codes
	localparam logic [OP_W-1:0] OP_READ_REQ  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ_RSP  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE_REQ = 2'd2;
	localparam logic [OP_W-1:0] OP_DATA      = 2'd3;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_COUNT = 2'd1;
	localparam logic [ST_W-1:0] ST_SEQUENCE  = 2'd2;

	// CRC and protocol constants
	localparam logic [WORD_W-1:0] CRC_INIT        = 16'hFFFF;
	localparam logic [WORD_W-1:0] CRC_POLY        = 16'hA001;
	localparam logic [BYTE_W-1:0] SINGLE_WRITE_FC = 8'd6;

	// Job kinds decided by the front end
	typedef enum logic [2:0] {
		K_ERR,
		K_RDREQ,
		K_RDRSP,
		K_WRSGL,
		K_WRMUL,
		K_DATA
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [ST_W-1:0]    status;
		logic               last_word;
		logic [BYTE_W-1:0]  slave;
		logic [BYTE_W-1:0]  fc;
		logic [WORD_W-1:0]  addr;
		logic [CNT_W-1:0]   cnt;
		logic [WORD_W-1:0]  val;
	} job_t;

	// Fold one byte into the reflected CRC-16
	function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> src/rfb_front.sv
// Front end of the RTU frame builder: accepts items, checks sequence and
// count, tracks the open frame and issues one job per item.
// Depends on rfb_pkg.
module rfb_front import rfb_pkg::*; #(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   operation,
	input  logic [BYTE_W-1:0] slave_address,
	input  logic [BYTE_W-1:0] func_code,
	input  logic [WORD_W-1:0] register_address,
	input  logic [WORD_W-1:0] register_count,
	input  logic [WORD_W-1:0] word_value,
	output logic              job_valid,
	input  logic              job_ready,
	output job_t              job
);

	localparam int WL_W = $clog2(MAX_WORDS + 1);

	logic            frame_open_q;
	logic [WL_W-1:0] words_left_q;
	logic            frame_open_d;
	logic [WL_W-1:0] words_left_d;
	logic            accept;
	logic            bad_count;

	assign in_ready  = job_ready;
	assign job_valid = in_valid;
	assign accept    = in_valid && job_ready;
	assign bad_count = (register_count == '0) || (register_count > WORD_W'(MAX_WORDS));

	// Classify the item and compute the next frame state
	always_comb begin
		job.kind      = K_ERR;
		job.status    = ST_OK;
		job.last_word = (words_left_q == WL_W'(1));
		job.slave     = slave_address;
		job.fc        = func_code;
		job.addr      = register_address;
		job.cnt       = register_count[CNT_W-1:0];
		job.val       = word_value;
		frame_open_d  = frame_open_q;
		words_left_d  = words_left_q;
		if (operation == OP_DATA) begin
			if (!frame_open_q || words_left_q == '0) begin
				job.status = ST_SEQUENCE;
			end else begin
				job.kind     = K_DATA;
				words_left_d = words_left_q - WL_W'(1);
				frame_open_d = (words_left_q != WL_W'(1));
			end
		end else if (frame_open_q) begin
			job.status = ST_SEQUENCE;
		end else if (bad_count) begin
			job.status = ST_BAD_COUNT;
		end else begin
			unique case (operation)
				OP_READ_REQ: begin
					job.kind = K_RDREQ;
				end
				OP_READ_RSP: begin
					job.kind     = K_RDRSP;
					frame_open_d = 1'b1;
					words_left_d = register_count[WL_W-1:0];
				end
				default: begin
					if (func_code == SINGLE_WRITE_FC) begin
						job.kind = K_WRSGL;
					end else begin
						job.kind     = K_WRMUL;
						frame_open_d = 1'b1;
						words_left_d = register_count[WL_W-1:0];
					end
				end
			endcase
		end
	end

	// Hold frame state, advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			words_left_q <= '0;
		end else if (accept) begin
			frame_open_q <= frame_open_d;
			words_left_q <= words_left_d;
		end
	end

	a_open_has_words: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> words_left_q != '0)
		else $error("open frame with no words left");

	a_closed_no_words: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_open_q |-> words_left_q == '0)
		else $error("closed frame with words left");

	a_last_word_closes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && job.kind == K_DATA && job.last_word |=> !frame_open_q)
		else $error("frame still open after last data word");

endmodule

>>> src/rfb_queue.sv
// Job queue between front and back end of the RTU frame builder.
// Small register FIFO of job_t entries. Depends on rfb_pkg.
module rfb_queue import rfb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop,
	output job_t pop_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");

	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty queue");

	a_ptrs_match_empty: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("empty queue with unequal pointers");

endmodule

>>> src/rfb_back.sv
// Back end of the RTU frame builder: serializes each job into line bytes,
// one per cycle unless the output stalls, keeps the running CRC and
// drives the output register. Depends on rfb_pkg.
module rfb_back import rfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  job_t              job,
	output logic              job_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] frame_byte,
	output logic              last_byte,
	output logic [ST_W-1:0]   status
);

	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] crc_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] frame_byte_q;
	logic              last_byte_q;
	logic [ST_W-1:0]   status_q;

	logic [BYTE_W-1:0] data_byte;
	logic              sel_crc_lo;
	logic              sel_crc_hi;
	logic              job_end;
	logic              is_err;
	logic              step;
	logic [BYTE_W-1:0] byte_d;
	logic [BYTE_W-1:0] cnt_x2;

	assign cnt_x2 = {job.cnt[CNT_W-2:0], 1'b0};
	assign is_err = (job.kind == K_ERR);
	assign step   = job_valid && (!out_valid_q || out_ready);
	assign job_pop = step && job_end;

	// Decode the byte for this job and position
	always_comb begin
		data_byte  = '0;
		sel_crc_lo = 1'b0;
		sel_crc_hi = 1'b0;
		job_end    = 1'b0;
		unique case (job.kind)
			K_DATA: begin
				case (idx_q)
					3'd0: data_byte = job.val[15:8];
					3'd1: begin
						data_byte = job.val[7:0];
						job_end   = !job.last_word;
					end
					3'd2: sel_crc_lo = 1'b1;
					default: begin
						sel_crc_hi = 1'b1;
						job_end    = 1'b1;
					end
				endcase
			end
			K_RDRSP: begin
				case (idx_q)
					3'd0: data_byte = job.slave;
					3'd1: data_byte = job.fc;
					default: begin
						data_byte = cnt_x2;
						job_end   = 1'b1;
					end
				endcase
			end
			K_RDREQ, K_WRSGL, K_WRMUL: begin
				case (idx_q)
					3'd0: data_byte = job.slave;
					3'd1: data_byte = job.fc;
					3'd2: data_byte = job.addr[15:8];
					3'd3: data_byte = job.addr[7:0];
					3'd4: data_byte = (job.kind == K_WRSGL) ? job.val[15:8] : 8'h00;
					3'd5: data_byte = (job.kind == K_WRSGL) ? job.val[7:0] : job.cnt;
					3'd6: begin
						if (job.kind == K_WRMUL) begin
							data_byte = cnt_x2;
							job_end   = 1'b1;
						end else begin
							sel_crc_lo = 1'b1;
						end
					end
					default: begin
						sel_crc_hi = 1'b1;
						job_end    = 1'b1;
					end
				endcase
			end
			default: begin
				job_end = 1'b1;
			end
		endcase
	end

	assign byte_d = sel_crc_lo ? crc_q[7:0] : (sel_crc_hi ? crc_q[15:8] : data_byte);

	// Advance byte position and CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= CRC_INIT;
		end else if (step) begin
			idx_q <= job_end ? '0 : idx_q + IDX_W'(1);
			if (sel_crc_hi) begin
				crc_q <= CRC_INIT;
			end else if (!sel_crc_lo && !is_err) begin
				crc_q <= crc_feed(crc_q, data_byte);
			end
		end
	end

	// Hold the output register until the request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			frame_byte_q <= is_err ? '0 : byte_d;
			last_byte_q  <= is_err || sel_crc_hi;
			status_q     <= is_err ? job.status : ST_OK;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign last_byte  = last_byte_q;
	assign status     = status_q;

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> last_byte_q && frame_byte_q == '0)
		else $error("error result not a single zero last byte");

	a_crc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && sel_crc_hi |=> crc_q == CRC_INIT)
		else $error("CRC not restarted after frame end");

	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> job_valid)
		else $error("job left the queue while in progress");

endmodule

>>> src/rtu_frame_builder_crc16.sv
// Top level of the RTU frame builder with CRC-16.
// Connects rfb_front, rfb_queue and rfb_back. Depends on rfb_pkg.
//
// Usage:
//   Input items arrive on s_axis: tuser carries the operation (read request,
//   read response, write request, data word), tdata the header fields and
//   the data word. Each accepted item yields one or more line bytes on
//   m_axis: tdata is the byte, tlast marks the final byte of a frame or an
//   error result, tuser carries the status (ok, bad count, out of sequence).
//   The front end checks each item in the cycle it is accepted and queues a
//   job; the back end emits one byte per cycle unless m_axis stalls, and folds
//   payload bytes into the reflected CRC-16, which closes each frame low byte
//   first. With the back end idle, an accepted item is written into the job
//   queue and its first byte is then registered into the output register.
//   Throughput: one line byte per cycle unless m_axis stalls; a data word
//   gives two bytes (four with the closing CRC) and a full header up to eight;
//   the byte serializer in the back end sets the rate. The front keeps
//   accepting while the job queue has room.
//   Reset clears the frame state, the queue and the output register; the
//   CRC restarts at all ones. When m_axis_tready is low the output byte
//   holds, the back end stops, and s_axis_tready falls once the queue fills.
module rtu_frame_builder_crc16 import rfb_pkg::*; #(
	parameter int MAX_WORDS   = MAX_WORDS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// slave_address[7:0], func_code[15:8], register_address[31:16],
	// register_count[47:32], word_value[63:48]
	input  logic [63:0] s_axis_tdata,
	// operation[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// frame_byte[7:0]
	output logic [7:0]  m_axis_tdata,
	// last_byte
	output logic        m_axis_tlast,
	// status[1:0]
	output logic [1:0]  m_axis_tuser
);

	logic front_valid;
	logic front_ready;
	job_t front_job;
	logic back_valid;
	logic back_pop;
	job_t back_job;

	// Accept and classify items
	rfb_front #(
		.MAX_WORDS(MAX_WORDS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.operation       (s_axis_tuser),
		.slave_address   (s_axis_tdata[7:0]),
		.func_code       (s_axis_tdata[15:8]),
		.register_address(s_axis_tdata[31:16]),
		.register_count  (s_axis_tdata[47:32]),
		.word_value      (s_axis_tdata[63:48]),
		.job_valid       (front_valid),
		.job_ready       (front_ready),
		.job             (front_job)
	);

	// Buffer jobs between the two halves
	rfb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_job  (front_job),
		.pop_valid (back_valid),
		.pop       (back_pop),
		.pop_job   (back_job)
	);

	// Serialize jobs into line bytes
	rfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (back_valid),
		.job       (back_job),
		.job_pop   (back_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.frame_byte(m_axis_tdata),
		.last_byte (m_axis_tlast),
		.status    (m_axis_tuser)
	);

endmodule
